/* rtl/rc_pkg.sv */
package rc_pkg;

    localparam int VALUE_BITS = 31;
    // remainder chunks of the output divider, eight quotient bits per cycle
    localparam int CHUNK_BITS = 8;
    localparam int DIV_W      = ((VALUE_BITS + CHUNK_BITS - 1) / CHUNK_BITS) * CHUNK_BITS;
    localparam int CHUNKS     = DIV_W / CHUNK_BITS;
    localparam int CHUNK_W    = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    // digit stack of the back end
    localparam int STACK_D    = VALUE_BITS;
    localparam int IDX_W      = $clog2(STACK_D);
    localparam int CNT_W      = $clog2(STACK_D + 1);
    // decimal split: q = (n * RECIP10) >> RECIP_SH, exact for n below 2**32
    localparam logic [31:0] RECIP10  = 32'hCCCC_CCCD;
    localparam int          RECIP_SH = 35;

    localparam logic [1:0] ST_OK          = 2'd0;
    localparam logic [1:0] ST_BAD_IN_BASE = 2'd1;
    localparam logic [1:0] ST_BAD_DIGIT   = 2'd2;
    localparam logic [1:0] ST_BAD_OUT_BASE = 2'd3;

    localparam logic [7:0] IN_BASE_MIN  = 8'd2;
    localparam logic [7:0] IN_BASE_MAX  = 8'd10;
    localparam logic [7:0] OUT_BASE_MIN = 8'd2;
    localparam logic [7:0] OUT_BASE_MAX = 8'd16;

    typedef struct packed {
        logic [1:0]            status;
        logic [VALUE_BITS-1:0] value;
        logic [4:0]            base;
    } t_job;

    function automatic logic [6:0] digit_glyph(input logic [3:0] d);
        logic [6:0] g;
        if (d < 4'd10) begin
            g = 7'h30 + 7'(d);
        end else begin
            g = 7'h41 + 7'(d) - 7'd10;
        end
        return g;
    endfunction

endpackage

/* rtl/rc_front.sv */
module rc_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [30:0]   i_number_in,
    input  logic [7:0]    i_input_base,
    input  logic [7:0]    i_output_base,
    output logic          o_busy,
    output logic          o_push,
    output rc_pkg::t_job  o_job,
    input  logic          i_full
);
    import rc_pkg::*;

    localparam logic [2:0] F_IDLE = 3'd0;
    localparam logic [2:0] F_DIV  = 3'd1;
    localparam logic [2:0] F_REM  = 3'd2;
    localparam logic [2:0] F_ACC  = 3'd3;
    localparam logic [2:0] F_PUSH = 3'd4;

    localparam int PW = VALUE_BITS + 4;

    logic [2:0]            r_state, n_state;
    logic [VALUE_BITS-1:0] r_num, n_num;
    logic [VALUE_BITS-1:0] r_q, n_q;
    logic [3:0]            r_rem, n_rem;
    logic [VALUE_BITS-1:0] r_acc, n_acc;
    logic [VALUE_BITS-1:0] r_pow, n_pow;
    logic [3:0]            r_ib, n_ib;
    logic [4:0]            r_ob, n_ob;
    logic                  r_ob_bad, n_ob_bad;
    logic [1:0]            r_st, n_st;

    logic [63:0]           prod;
    logic [VALUE_BITS-1:0] q_x10;
    logic [VALUE_BITS-1:0] diff;
    logic [PW-1:0]         term;
    logic [PW-1:0]         pow_next;
    logic                  ib_bad;
    logic                  ob_bad;

    assign prod     = 64'(r_num) * 64'(RECIP10);
    assign q_x10    = (r_q << 3) + (r_q << 1);
    assign diff     = r_num - q_x10;
    assign term     = PW'(r_rem) * PW'(r_pow);
    assign pow_next = PW'(r_pow) * PW'(r_ib);
    assign ib_bad   = (i_input_base < IN_BASE_MIN) || (i_input_base > IN_BASE_MAX);
    assign ob_bad   = (i_output_base < OUT_BASE_MIN) || (i_output_base > OUT_BASE_MAX);

    assign o_busy = (r_state != F_IDLE);
    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_job  = '{status: r_st, value: r_acc, base: r_ob};

    always_comb begin
        n_state  = r_state;
        n_num    = r_num;
        n_q      = r_q;
        n_rem    = r_rem;
        n_acc    = r_acc;
        n_pow    = r_pow;
        n_ib     = r_ib;
        n_ob     = r_ob;
        n_ob_bad = r_ob_bad;
        n_st     = r_st;
        unique case (r_state)
            F_IDLE: begin
                if (i_start) begin
                    n_num    = VALUE_BITS'(i_number_in);
                    n_acc    = '0;
                    n_pow    = VALUE_BITS'(1);
                    n_ib     = i_input_base[3:0];
                    n_ob     = i_output_base[4:0];
                    n_ob_bad = ob_bad;
                    if (ib_bad) begin
                        n_st    = ST_BAD_IN_BASE;
                        n_state = F_PUSH;
                    end else begin
                        n_st    = ST_OK;
                        n_state = F_DIV;
                    end
                end
            end
            F_DIV: begin
                n_q     = VALUE_BITS'(prod >> RECIP_SH);
                n_state = F_REM;
            end
            F_REM: begin
                n_rem = diff[3:0];
                if (diff[3:0] >= r_ib) begin
                    n_st    = ST_BAD_DIGIT;
                    n_state = F_PUSH;
                end else begin
                    n_state = F_ACC;
                end
            end
            F_ACC: begin
                n_acc = r_acc + VALUE_BITS'(term);
                n_pow = VALUE_BITS'(pow_next);
                n_num = r_q;
                if (r_q == '0) begin
                    n_st    = r_ob_bad ? ST_BAD_OUT_BASE : ST_OK;
                    n_state = F_PUSH;
                end else begin
                    n_state = F_DIV;
                end
            end
            F_PUSH: begin
                if (!i_full) begin
                    n_state = F_IDLE;
                end
            end
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_num    <= n_num;
        r_q      <= n_q;
        r_rem    <= n_rem;
        r_acc    <= n_acc;
        r_pow    <= n_pow;
        r_ib     <= n_ib;
        r_ob     <= n_ob;
        r_ob_bad <= n_ob_bad;
        r_st     <= n_st;
    end

endmodule

/* rtl/rc_queue.sv */
module rc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  rc_pkg::t_job  i_job,
    input  logic          i_pop,
    output rc_pkg::t_job  o_job,
    output logic          o_empty,
    output logic          o_full
);
    import rc_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [PTR_W:0]   r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == (PTR_W+1)'(DEPTH));
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

/* rtl/rc_back.sv */
module rc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  rc_pkg::t_job  i_job,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_valid,
    output logic [6:0]    o_digit_char,
    output logic [1:0]    o_status,
    output logic          o_last
);
    import rc_pkg::*;

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    logic [1:0]         r_state;
    logic [DIV_W-1:0]   r_val;
    logic [4:0]         r_ob;
    logic [3:0]         r_rem;
    logic [CHUNK_W-1:0] r_chunk;
    logic [CNT_W-1:0]   r_cnt;
    logic [3:0]         r_stack [STACK_D];

    logic [CHUNK_BITS-1:0] qbits;
    logic [3:0]            rem_next;
    logic [DIV_W-1:0]      val_next;
    logic [4:0]            t;
    logic [3:0]            rem_w;
    logic [CNT_W-1:0]      top;

    // restoring division of one chunk, remainder stays below the base
    always_comb begin
        rem_w = r_rem;
        qbits = '0;
        t     = '0;
        for (int k = 0; k < CHUNK_BITS; k++) begin
            t = {rem_w, r_val[DIV_W-1-k]};
            if (t >= r_ob) begin
                qbits[CHUNK_BITS-1-k] = 1'b1;
                rem_w = 4'(t - r_ob);
            end else begin
                rem_w = t[3:0];
            end
        end
        rem_next = rem_w;
        val_next = {r_val[DIV_W-CHUNK_BITS-1:0], qbits};
    end

    assign o_pop = (r_state == B_IDLE) && !i_empty;
    assign top   = r_cnt - 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                B_IDLE: begin
                    if (!i_empty) begin
                        if (i_job.status != ST_OK) begin
                            o_valid <= 1'b1;
                        end else begin
                            r_state <= B_DIV;
                        end
                    end
                end
                B_DIV: begin
                    if (r_chunk == CHUNK_W'(CHUNKS - 1) && val_next == '0) begin
                        r_state <= B_EMIT;
                    end
                end
                B_EMIT: begin
                    o_valid <= 1'b1;
                    if (r_cnt == CNT_W'(1)) begin
                        r_state <= B_IDLE;
                    end
                end
                default: r_state <= B_IDLE;
            endcase
        end

        unique case (r_state)
            B_IDLE: begin
                r_val        <= DIV_W'(i_job.value);
                r_ob         <= i_job.base;
                r_rem        <= '0;
                r_chunk      <= '0;
                r_cnt        <= '0;
                o_digit_char <= '0;
                o_status     <= i_job.status;
                o_last       <= 1'b1;
            end
            B_DIV: begin
                r_val <= val_next;
                if (r_chunk == CHUNK_W'(CHUNKS - 1)) begin
                    r_stack[r_cnt[IDX_W-1:0]] <= rem_next;
                    r_cnt   <= r_cnt + 1'b1;
                    r_rem   <= '0;
                    r_chunk <= '0;
                end else begin
                    r_rem   <= rem_next;
                    r_chunk <= r_chunk + 1'b1;
                end
            end
            B_EMIT: begin
                o_digit_char <= digit_glyph(r_stack[top[IDX_W-1:0]]);
                o_status     <= ST_OK;
                o_last       <= (r_cnt == CNT_W'(1));
                r_cnt        <= top;
            end
            default: ;
        endcase
    end

endmodule

/* rtl/radix_converter.sv */
// Radix converter: a word on i_number_in is read digit by decimal digit as a
// numeral in i_input_base (2 to 10) and is sent out in i_output_base (2 to 16)
// as ASCII characters, most significant first, one per o_valid cycle, with
// o_last on the final one. A bad request gives one result with o_digit_char 0,
// the code on o_status and o_last set. The receiver cannot stall: every
// o_valid cycle must be taken. A word is taken when start is high and busy is
// low. The front end takes the word, then steps through split by ten, digit
// check and weighted accumulate (digit times a running power of the input
// base) for each decimal digit checked (none for a bad input base, and it stops
// at the first bad digit), and then hands the job to a two-entry queue.
// busy is high from the edge that takes the word through the hand-over cycle,
// and stays high longer while the queue is full. The back end then picks the
// job up, divides by the output base chunk by chunk (eight quotient bits a
// cycle), pushing one remainder per output digit on a digit stack, and emits
// the digits from the stack. While the back end emits, the front end already
// works on the next word.
module radix_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [30:0] i_number_in,
    input  logic [7:0]  i_input_base,
    input  logic [7:0]  i_output_base,
    output logic        o_valid,
    output logic [6:0]  o_digit_char,
    output logic [1:0]  o_status,
    output logic        o_last
);
    import rc_pkg::*;

    logic push;
    logic pop;
    logic q_empty;
    logic q_full;
    t_job push_job;
    t_job head_job;

    rc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .i_number_in   (i_number_in),
        .i_input_base  (i_input_base),
        .i_output_base (i_output_base),
        .o_busy        (busy),
        .o_push        (push),
        .o_job         (push_job),
        .i_full        (q_full)
    );

    rc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    rc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (head_job),
        .i_empty      (q_empty),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .o_digit_char (o_digit_char),
        .o_status     (o_status),
        .o_last       (o_last)
    );

endmodule
